FILE: sv/tsg_pkg.sv
// Shared types and constants for the touch swipe gesture classifier.
// No dependencies; imported by every module of the block.
`default_nettype none
package tsg_pkg;

  // Elapsed-time counter width (default for the top-level parameter)
  localparam int ELAPSED_BITS_DEF = 16;

  // Result queue depth: room for three items of two beats each
  localparam int OQ_DEPTH = 6;

  // Configuration register indexes
  localparam logic [1:0] REG_LONG_PRESS = 2'd0;
  localparam logic [1:0] REG_SWIPE_MIN  = 2'd1;
  localparam logic [1:0] REG_SLIP_MAX   = 2'd2;
  localparam logic [1:0] REG_TAP_MAX    = 2'd3;

  // Configuration reset values
  localparam logic [15:0] LONG_PRESS_RST = 16'd680;
  localparam logic [7:0]  SWIPE_MIN_RST  = 8'd15;
  localparam logic [7:0]  SLIP_MAX_RST   = 8'd10;
  localparam logic [7:0]  TAP_MAX_RST    = 8'd3;

  // Report bytes
  localparam logic [7:0] STATUS_PRESSED  = 8'd1;
  localparam logic [7:0] STATUS_RELEASED = 8'd2;
  localparam logic [7:0] SLIP_NONE       = 8'd0;
  localparam logic [7:0] SLIP_UP         = 8'd1;
  localparam logic [7:0] SLIP_DOWN       = 8'd2;

  // Decoded event; its code doubles as the result kind
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_PRESS    = 3'd1,
    EV_UP       = 3'd2,
    EV_UPSLIP   = 3'd3,
    EV_DOWNSLIP = 3'd4
  } ev_t;

  localparam logic [2:0] KIND_GESTURE = 3'd5;

  // Gesture codes
  localparam logic [8:0] CODE_UP    = 9'd3;
  localparam logic [8:0] CODE_DOWN  = 9'd4;
  localparam logic [8:0] CODE_LEFT  = 9'd5;
  localparam logic [8:0] CODE_RIGHT = 9'd6;
  localparam logic [8:0] CODE_TAP   = 9'd101;

  typedef struct packed {
    logic [15:0] long_press_ms;
    logic [7:0]  swipe_min_distance;
    logic [7:0]  slip_max_distance;
    logic [7:0]  tap_max_distance;
  } cfg_t;

  typedef struct packed {
    logic       action;
    logic [7:0] press_status;
    logic [7:0] slip_code;
    logic [7:0] position;
    logic [7:0] end_position;
  } item_t;

  typedef struct packed {
    logic signed [8:0] value;
    logic [2:0]        kind;
    logic              last;
  } res_t;

endpackage
`default_nettype wire

FILE: sv/tsg_core.sv
// Gesture state and classification: one registered item per cycle in,
// up to two result beats out. Depends on tsg_pkg.
`default_nettype none
module tsg_core
  import tsg_pkg::*;
#(
  parameter int ELAPSED_BITS = ELAPSED_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       item_valid,
  input  wire item_t      item,
  output logic [1:0]      res_n,
  output res_t            res0,
  output res_t            res1
);

  localparam int CW = (ELAPSED_BITS > 16) ? ELAPSED_BITS : 16;

  logic                    pressed_r, pressed_nxt;
  logic [7:0]              first_r, first_nxt;
  logic [7:0]              last_r, last_nxt;
  logic                    lps_r, lps_nxt;
  logic [ELAPSED_BITS-1:0] elapsed_r, elapsed_nxt;
  logic                    tv_r, tv_nxt;

  ev_t         ev;
  logic [CW-1:0] el_ext, lpm_ext;
  logic [7:0]  lastv, pos_gap;
  logic [8:0]  side;

  always_comb begin
    priority if (item.press_status == STATUS_PRESSED) ev = EV_PRESS;
    else if (item.press_status == STATUS_RELEASED && item.slip_code == SLIP_NONE) ev = EV_UP;
    else if (item.slip_code == SLIP_UP) ev = EV_UPSLIP;
    else if (item.slip_code == SLIP_DOWN) ev = EV_DOWNSLIP;
    else ev = EV_NONE;
  end

  assign el_ext  = CW'(elapsed_r);
  assign lpm_ext = CW'(cfg.long_press_ms);
  // release position overrides the last seen one when nonzero
  assign lastv   = (item.end_position != 8'd0) ? item.end_position : last_r;
  assign pos_gap = (lastv > first_r) ? (lastv - first_r) : (first_r - lastv);
  assign side    = (lastv > first_r) ? CODE_RIGHT : CODE_LEFT;

  always_comb begin
    pressed_nxt = pressed_r;
    first_nxt   = first_r;
    last_nxt    = last_r;
    lps_nxt     = lps_r;
    elapsed_nxt = elapsed_r;
    tv_nxt      = tv_r;
    res_n       = 2'd0;
    res0        = '0;
    res1        = '0;
    if (item_valid) begin
      if (!item.action) begin
        if (tv_r && !(&elapsed_r)) elapsed_nxt = elapsed_r + 1'b1;
      end else if (!pressed_r) begin
        if (ev == EV_PRESS) begin
          pressed_nxt = 1'b1;
          first_nxt   = 8'd0;
          last_nxt    = 8'd0;
          lps_nxt     = 1'b0;
          if (item.position != 8'd0) begin
            first_nxt   = item.position;
            last_nxt    = item.position;
            elapsed_nxt = '0;
            tv_nxt      = 1'b1;
          end
        end
      end else if (ev == EV_PRESS) begin
        if (item.position != 8'd0) begin
          if (last_r == 8'd0) begin
            first_nxt   = item.position;
            last_nxt    = item.position;
            elapsed_nxt = '0;
            tv_nxt      = 1'b1;
          end else begin
            if (el_ext > lpm_ext) begin
              if (!lps_r) begin
                // first long-press report: zero delta, then offset from start
                lps_nxt    = 1'b1;
                res_n      = 2'd2;
                res0.value = 9'sd0;
                res0.kind  = EV_PRESS;
                res1.value = $signed({1'b0, item.position} - {1'b0, first_r});
                res1.kind  = EV_PRESS;
              end else begin
                res_n      = 2'd1;
                res0.value = $signed({1'b0, item.position} - {1'b0, last_r});
                res0.kind  = EV_PRESS;
              end
            end
            last_nxt = item.position;
          end
        end
      end else begin
        pressed_nxt = 1'b0;
        if (tv_r) begin
          if (el_ext < lpm_ext) begin
            res0.kind = KIND_GESTURE;
            if (ev != EV_UP) begin
              if (pos_gap > cfg.swipe_min_distance) begin
                res_n      = 2'd1;
                res0.value = $signed(side);
              end else if (pos_gap < cfg.slip_max_distance) begin
                res_n      = 2'd1;
                res0.value = $signed((ev == EV_DOWNSLIP) ? CODE_DOWN : CODE_UP);
              end
            end else if (pos_gap > cfg.tap_max_distance) begin
              res_n      = 2'd1;
              res0.value = $signed(side);
            end else begin
              res_n      = 2'd1;
              res0.value = $signed(CODE_TAP);
            end
          end else begin
            res_n      = 2'd1;
            res0.value = 9'sd0;
            res0.kind  = ev;
          end
        end
        first_nxt = 8'd0;
        last_nxt  = 8'd0;
        tv_nxt    = 1'b0;
      end
    end
    if (res_n == 2'd1) res0.last = 1'b1;
    if (res_n == 2'd2) res1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r <= 1'b0;
      first_r   <= 8'd0;
      last_r    <= 8'd0;
      lps_r     <= 1'b0;
      elapsed_r <= '0;
      tv_r      <= 1'b0;
    end else begin
      pressed_r <= pressed_nxt;
      first_r   <= first_nxt;
      last_r    <= last_nxt;
      lps_r     <= lps_nxt;
      elapsed_r <= elapsed_nxt;
      tv_r      <= tv_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/tsg_outq.sv
// Result queue: takes up to two beats a cycle, hands out one per cycle while pop_ready is high.
// Depends on tsg_pkg.
`default_nettype none
module tsg_outq
  import tsg_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [1:0]                  push_n,
  input  wire res_t                        push0,
  input  wire res_t                        push1,
  output logic                             pop_valid,
  input  wire logic                        pop_ready,
  output res_t                             pop_data,
  output logic [$clog2(OQ_DEPTH+1)-1:0]    count
);

  localparam int IW = $clog2(OQ_DEPTH);
  localparam int NW = $clog2(OQ_DEPTH + 1);

  res_t          entries_r [OQ_DEPTH];
  logic [IW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] wr_p1;
  logic          pop;

  function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p);
    ptr_inc = (p == IW'(OQ_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_p1     = ptr_inc(wr_r);
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = entries_r[rd_r];
  assign pop       = pop_valid && pop_ready;
  assign count     = cnt_r;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = pop ? ptr_inc(rd_r) : rd_r;
    cnt_nxt = cnt_r + NW'(push_n) - NW'(pop);
    unique case (push_n)
      2'd1:    wr_nxt = wr_p1;
      2'd2:    wr_nxt = ptr_inc(wr_p1);
      default: wr_nxt = wr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) entries_r[wr_r] <= push0;
    if (push_n == 2'd2) entries_r[wr_p1] <= push1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/touch_swipe_gesture_classifier.sv
// Touch swipe gesture classifier, top level. Uses tsg_pkg, tsg_core, tsg_outq.
// From input beat to first result beat: input register, then classification into
// the result queue, whose head drives the output.
// Throughput: one input beat per cycle, and input stalls only when the six-entry
// queue is short of room; an item with two result beats sends them on the output
// in turn. Reset (rst_n low, synchronous) idles the tracker and restores config.
`default_nettype none
module touch_swipe_gesture_classifier
  import tsg_pkg::*;
#(
  parameter int ELAPSED_BITS = ELAPSED_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,  // press_status, slip_code, position, end_position
  input  wire logic        in_tuser,  // action: 0 tick, 1 touch report
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata, // value[8:0], zero pad
  output logic [2:0]       out_tuser, // kind
  output logic             out_tlast,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  localparam int NW = $clog2(OQ_DEPTH + 1);

  cfg_t          cfg_r;
  logic          s1_valid_r;
  item_t         s1_item_r;
  logic          in_acc;
  logic [1:0]    res_n;
  res_t          res0, res1, head;
  logic [NW-1:0] q_count;
  logic [NW:0]   q_commit;

  // ---- configuration registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ms      <= LONG_PRESS_RST;
      cfg_r.swipe_min_distance <= SWIPE_MIN_RST;
      cfg_r.slip_max_distance  <= SLIP_MAX_RST;
      cfg_r.tap_max_distance   <= TAP_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_LONG_PRESS: cfg_r.long_press_ms      <= cfg_wdata;
        REG_SWIPE_MIN:  cfg_r.swipe_min_distance <= cfg_wdata[7:0];
        REG_SLIP_MAX:   cfg_r.slip_max_distance  <= cfg_wdata[7:0];
        REG_TAP_MAX:    cfg_r.tap_max_distance   <= cfg_wdata[7:0];
        default:        ;
      endcase
    end
  end

  // ---- input register ----
  // Accept only when the queue can absorb two beats for this item on top of
  // whatever the item already in the input register may still add.
  assign q_commit  = {1'b0, q_count} + (s1_valid_r ? (NW+1)'(2) : '0);
  assign in_tready = (q_commit <= (NW+1)'(OQ_DEPTH - 2));
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else        s1_valid_r <= in_acc;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.action       <= in_tuser;
      s1_item_r.press_status <= in_tdata[7:0];
      s1_item_r.slip_code    <= in_tdata[15:8];
      s1_item_r.position     <= in_tdata[23:16];
      s1_item_r.end_position <= in_tdata[31:24];
    end
  end

  // ---- classification ----
  tsg_core #(
    .ELAPSED_BITS(ELAPSED_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (s1_valid_r),
    .item       (s1_item_r),
    .res_n      (res_n),
    .res0       (res0),
    .res1       (res1)
  );

  // ---- result queue ----
  tsg_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (res_n),
    .push0     (res0),
    .push1     (res1),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_data  (head),
    .count     (q_count)
  );

  assign out_tdata = {7'd0, head.value};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

  // ---- checks ----
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= NW'(OQ_DEPTH))
    else $error("result queue over depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, q_count} + (NW+1)'(res_n)) <= (NW+1)'(OQ_DEPTH))
    else $error("result push with no room");

  a_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_item_r.action) |-> (res_n == 2'd0))
    else $error("tick produced a result");

  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> (res_n == 2'd0))
    else $error("result without an item");

endmodule
`default_nettype wire
